// ===== rtl/postfix_expression_evaluator_unit_assert.svh =====
// Assertion macros used by the checker module of the postfix evaluator.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFX_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFX_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pfx_pkg.sv =====
package pfx_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int DATA_W          = 32;
	localparam int SYM_W           = 8;
	localparam int STAT_W          = 3;

	localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [SYM_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CHAR_STAR  = 8'h2A;
	localparam logic [SYM_W-1:0] CHAR_SLASH = 8'h2F;
	localparam logic [SYM_W-1:0] CHAR_NL    = 8'h0A;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_UNDERFLOW = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_BADSYM    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		WR_DIGIT,
		WR_ADD,
		WR_SUB,
		WR_MUL,
		WR_DIV,
		WR_ZERO
	} wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    rd_en;
		logic    rd_next;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    clear;
		logic    ld_b;
		logic    ld_a;
		logic    mul_ld;
		logic    div_start;
		logic    div_step;
		logic    flag_en;
		status_t flag_code;
		logic    load_out;
	} pfx_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic lt2;
		logic full;
		logic b_zero;
		logic div_last;
	} pfx_stat_t;

	function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic in_range;
		in_range = (&v[63:31]) || !(|v[63:31]);
		if (in_range) begin
			return v[31:0];
		end
		return v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

endpackage

// ===== rtl/pfx_sym_if.sv =====
interface pfx_sym_if import pfx_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;

	modport source (output valid, output symbol, input ready);
	modport sink (input valid, input symbol, output ready);
endinterface

// ===== rtl/pfx_res_if.sv =====
interface pfx_res_if import pfx_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_value;
	logic [STAT_W-1:0]        status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink (input valid, input result_value, input status, output ready);
endinterface

// ===== rtl/pfx_datapath.sv =====
module pfx_datapath import pfx_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [SYM_W-1:0]         symbol,
	input  pfx_cmd_t                 cmd,
	output pfx_stat_t                stat,
	output logic signed [DATA_W-1:0] result_value,
	output logic [STAT_W-1:0]        status
);

	localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW  = $clog2(STACK_DEPTH + 1);
	localparam int DW  = DATA_W + FRAC_BITS;
	localparam int DCW = $clog2(DW + 1);

	logic [DATA_W-1:0]        mem [STACK_DEPTH];
	logic [DATA_W-1:0]        rd_data_q;
	logic signed [DATA_W-1:0] a_q;
	logic signed [DATA_W-1:0] b_q;
	logic signed [63:0]       prod_q;
	logic [DW-1:0]            dq_q;
	logic [DATA_W-1:0]        rem_q;
	logic [DATA_W-1:0]        absb_q;
	logic                     neg_q;
	logic [DCW-1:0]           dcnt_q;
	logic [CW-1:0]            count_q;
	status_t                  sticky_q;
	logic [DATA_W-1:0]        result_value_q;
	status_t                  status_q;

	logic [AW-1:0]            top_addr;
	logic [AW-1:0]            next_addr;
	logic [AW-1:0]            push_addr;
	logic [AW-1:0]            wr_addr;
	logic [DATA_W-1:0]        wr_data;
	logic [3:0]               digit;
	logic signed [DATA_W:0]   sum_s;
	logic signed [DATA_W:0]   diff_s;
	logic signed [63:0]       mul_sh;
	logic signed [63:0]       quo_s;
	logic [DATA_W-1:0]        abs_a;
	logic [DATA_W-1:0]        abs_b;
	logic [DATA_W:0]          rem_sh;
	logic                     rem_ge;

	assign top_addr  = AW'(count_q - CW'(1));
	assign next_addr = AW'(count_q - CW'(2));
	assign push_addr = AW'(count_q);

	assign digit  = 4'(symbol - CHAR_ZERO);
	assign sum_s  = {a_q[DATA_W-1], a_q} + {b_q[DATA_W-1], b_q};
	assign diff_s = {a_q[DATA_W-1], a_q} - {b_q[DATA_W-1], b_q};
	assign mul_sh = prod_q >>> FRAC_BITS;
	assign quo_s  = neg_q ? -signed'(64'(dq_q)) : signed'(64'(dq_q));

	assign abs_a = a_q[DATA_W-1] ? DATA_W'(-a_q) : DATA_W'(a_q);
	assign abs_b = b_q[DATA_W-1] ? DATA_W'(-b_q) : DATA_W'(b_q);

	// One restoring division step: shift in the next dividend bit and subtract if it fits.
	assign rem_sh = {rem_q, dq_q[DW-1]};
	assign rem_ge = rem_sh >= {1'b0, absb_q};

	always_comb begin
		case (cmd.wr_sel)
			WR_DIGIT: wr_data = DATA_W'(digit) << FRAC_BITS;
			WR_ADD:   wr_data = sat32(64'(sum_s));
			WR_SUB:   wr_data = sat32(64'(diff_s));
			WR_MUL:   wr_data = sat32(mul_sh);
			WR_DIV:   wr_data = sat32(quo_s);
			default:  wr_data = '0;
		endcase
	end

	assign wr_addr = (cmd.wr_sel == WR_DIGIT) ? push_addr : next_addr;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[cmd.rd_next ? next_addr : top_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_b) begin
			b_q <= signed'(rd_data_q);
		end
		if (cmd.ld_a) begin
			a_q <= signed'(rd_data_q);
		end
		if (cmd.mul_ld) begin
			prod_q <= a_q * b_q;
		end
		if (cmd.div_start) begin
			dq_q   <= DW'(abs_a) << FRAC_BITS;
			rem_q  <= '0;
			absb_q <= abs_b;
			neg_q  <= a_q[DATA_W-1] ^ b_q[DATA_W-1];
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[DW-2:0], rem_ge};
			rem_q <= rem_ge ? DATA_W'(rem_sh - {1'b0, absb_q}) : rem_sh[DATA_W-1:0];
		end
		if (cmd.load_out) begin
			result_value_q <= stat.empty ? '0 : rd_data_q;
			if (stat.empty && sticky_q == ST_OK) begin
				status_q <= ST_UNDERFLOW;
			end else begin
				status_q <= sticky_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sticky_q <= ST_OK;
			dcnt_q   <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.clear) begin
				sticky_q <= ST_OK;
			end else if (cmd.flag_en && sticky_q == ST_OK) begin
				sticky_q <= cmd.flag_code;
			end
			if (cmd.div_start) begin
				dcnt_q <= DCW'(DW);
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q - DCW'(1);
			end
		end
	end

	assign stat.empty    = (count_q == '0);
	assign stat.lt2      = (count_q < CW'(2));
	assign stat.full     = (count_q == CW'(STACK_DEPTH));
	assign stat.b_zero   = (b_q == '0);
	assign stat.div_last = (dcnt_q == DCW'(1));

	assign result_value = signed'(result_value_q);
	assign status       = status_q;

endmodule

// ===== rtl/pfx_ctrl.sv =====
module pfx_ctrl import pfx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sym_valid,
	input  logic [SYM_W-1:0] symbol,
	output logic             sym_ready,
	output logic             res_valid,
	input  logic             res_ready,
	output pfx_cmd_t         cmd,
	input  pfx_stat_t        stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_B,
		S_RD_A,
		S_EXEC,
		S_MUL_WB,
		S_DIV_RUN,
		S_DIV_WB,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	state_t state_q;
	state_t state_d;
	op_t    op_q;
	op_t    op_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		op_d    = op_q;
		case (state_q)
			S_IDLE: begin
				if (sym_valid) begin
					if (symbol inside {[CHAR_ZERO:CHAR_NINE]}) begin
						if (stat.full) begin
							cmd.flag_en   = 1'b1;
							cmd.flag_code = ST_OVERFLOW;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_sel  = WR_DIGIT;
							cmd.cnt_inc = 1'b1;
						end
					end else if (symbol inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH}) begin
						if (stat.lt2) begin
							cmd.flag_en   = 1'b1;
							cmd.flag_code = ST_UNDERFLOW;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = S_RD_B;
							case (symbol)
								CHAR_PLUS:  op_d = OP_ADD;
								CHAR_MINUS: op_d = OP_SUB;
								CHAR_STAR:  op_d = OP_MUL;
								default:    op_d = OP_DIV;
							endcase
						end
					end else if (symbol == CHAR_NL) begin
						cmd.rd_en = 1'b1;
						state_d   = S_EMIT;
					end else begin
						cmd.flag_en   = 1'b1;
						cmd.flag_code = ST_BADSYM;
					end
				end
			end
			S_RD_B: begin
				cmd.ld_b    = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_next = 1'b1;
				state_d     = S_RD_A;
			end
			S_RD_A: begin
				cmd.ld_a = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				case (op_q)
					OP_ADD: begin
						cmd.wr_en   = 1'b1;
						cmd.wr_sel  = WR_ADD;
						cmd.cnt_dec = 1'b1;
						state_d     = S_IDLE;
					end
					OP_SUB: begin
						cmd.wr_en   = 1'b1;
						cmd.wr_sel  = WR_SUB;
						cmd.cnt_dec = 1'b1;
						state_d     = S_IDLE;
					end
					OP_MUL: begin
						cmd.mul_ld = 1'b1;
						state_d    = S_MUL_WB;
					end
					default: begin
						if (stat.b_zero) begin
							cmd.wr_en     = 1'b1;
							cmd.wr_sel    = WR_ZERO;
							cmd.cnt_dec   = 1'b1;
							cmd.flag_en   = 1'b1;
							cmd.flag_code = ST_DIVZERO;
							state_d       = S_IDLE;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV_RUN;
						end
					end
				endcase
			end
			S_MUL_WB: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_MUL;
				cmd.cnt_dec = 1'b1;
				state_d     = S_IDLE;
			end
			S_DIV_RUN: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_DIV_WB;
				end
			end
			S_DIV_WB: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_DIV;
				cmd.cnt_dec = 1'b1;
				state_d     = S_IDLE;
			end
			S_EMIT: begin
				// The top entry was read on the newline; wait for a free output slot.
				if (!out_valid_q || res_ready) begin
					cmd.load_out = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ADD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sym_ready = (state_q == S_IDLE);
	assign res_valid = out_valid_q;

endmodule

// ===== rtl/postfix_expression_evaluator_unit.sv =====
// Postfix (RPN) evaluator over signed fixed-point values with FRAC_BITS fractional bits and a
// stack of STACK_DEPTH entries. Send one ASCII character per transaction on sym; a newline
// produces one transaction on res with the top of stack and a status code (0 ok, 1 underflow,
// 2 overflow, 3 divide by zero, 4 bad symbol; the first error since the last newline wins),
// then empties the stack. Symbols are taken one at a time. / uses a restoring divider that
// produces one quotient bit per cycle, and a newline waits for any previous result to be
// taken. Further symbols are accepted while a result waits in the output register.
module postfix_expression_evaluator_unit import pfx_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pfx_sym_if.sink   sym,
	pfx_res_if.source res
);

	pfx_cmd_t  cmd;
	pfx_stat_t stat;

	pfx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym.valid),
		.symbol    (sym.symbol),
		.sym_ready (sym.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	pfx_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.symbol       (sym.symbol),
		.cmd          (cmd),
		.stat         (stat),
		.result_value (res.result_value),
		.status       (res.status)
	);

endmodule

// ===== rtl/pfx_checker.sv =====
`include "postfix_expression_evaluator_unit_assert.svh"

module pfx_checker import pfx_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     sym_valid,
	input logic                     sym_ready,
	input logic [SYM_W-1:0]         symbol,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic signed [DATA_W-1:0] result_value,
	input logic [STAT_W-1:0]        status
);

	`PFX_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`PFX_ASSERT_NXT(a_res_stable, res_valid && !res_ready, $stable(result_value) && $stable(status), "result changed while stalled")
	`PFX_ASSERT_IMP(a_status_range, res_valid, status <= STAT_W'(ST_BADSYM), "status code out of range")
	`PFX_ASSERT_NXT(a_nl_busy, sym_valid && sym_ready && symbol == CHAR_NL, !sym_ready, "symbol taken during newline")

endmodule

bind postfix_expression_evaluator_unit pfx_checker u_pfx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sym_valid    (sym.valid),
	.sym_ready    (sym.ready),
	.symbol       (sym.symbol),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.result_value (res.result_value),
	.status       (res.status)
);

// ===== bench/tb_postfix_expression_evaluator_unit.sv =====
module tb_postfix_expression_evaluator_unit import pfx_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;

	// Predicts the evaluator from the accepted characters and holds the
	// results that are still due on the result channel.
	class rpn_scoreboard;
		logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH_DEF];
		int unsigned depth;
		status_t sticky;
		logic signed [DATA_W-1:0] want_value [$];
		status_t want_status [$];
		int unsigned mismatches;

		function new();
			depth = 0;
			sticky = ST_OK;
			mismatches = 0;
		endfunction

		function int unsigned outstanding();
			return want_value.size();
		endfunction

		// Only the first error since the last newline is kept.
		function void raise(status_t code);
			if (sticky == ST_OK) begin
				sticky = code;
			end
		endfunction

		function void push_value(logic signed [DATA_W-1:0] v);
			if (depth >= STACK_DEPTH_DEF) begin
				raise(ST_OVERFLOW);
			end else begin
				stack_mem[depth] = v;
				depth++;
			end
		endfunction

		function logic signed [DATA_W-1:0] clamp_q16(longint r);
			if (r > 64'sd2147483647) begin
				return 32'sh7FFF_FFFF;
			end
			if (r < -64'sd2147483648) begin
				return 32'sh8000_0000;
			end
			return r[DATA_W-1:0];
		endfunction

		function void combine(logic [SYM_W-1:0] op);
			longint a;
			longint b;
			longint r;
			if (depth < 2) begin
				raise(ST_UNDERFLOW);
				return;
			end
			b = longint'(stack_mem[depth-1]);
			a = longint'(stack_mem[depth-2]);
			depth -= 2;
			case (op)
			CHAR_PLUS: r = a + b;
			CHAR_MINUS: r = a - b;
			// The arithmetic shift rounds toward minus infinity.
			CHAR_STAR: r = (a * b) >>> FRAC_BITS_DEF;
			default: begin
				if (b == 0) begin
					raise(ST_DIVZERO);
					r = 0;
				end else begin
					r = (a <<< FRAC_BITS_DEF) / b;
				end
			end
			endcase
			push_value(clamp_q16(r));
		endfunction

		function void note_symbol(logic [SYM_W-1:0] c);
			logic signed [DATA_W-1:0] digit_val;
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				digit_val = DATA_W'(c - CHAR_ZERO);
				push_value(digit_val <<< FRAC_BITS_DEF);
			end else if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR ||
					c == CHAR_SLASH) begin
				combine(c);
			end else if (c == CHAR_NL) begin
				if (depth == 0) begin
					want_value.push_back('0);
					want_status.push_back((sticky != ST_OK) ? sticky : ST_UNDERFLOW);
				end else begin
					want_value.push_back(stack_mem[depth-1]);
					want_status.push_back(sticky);
				end
				depth = 0;
				sticky = ST_OK;
			end else begin
				raise(ST_BADSYM);
			end
		endfunction

		function void check_result(logic signed [DATA_W-1:0] v, logic [STAT_W-1:0] st);
			logic signed [DATA_W-1:0] exp_v;
			status_t exp_s;
			if (want_value.size() == 0) begin
				$display("%0t: unexpected result, value %0d status %0d", $time, v, st);
				mismatches++;
				return;
			end
			exp_v = want_value.pop_front();
			exp_s = want_status.pop_front();
			if (v !== exp_v) begin
				$display("%0t: result_value expected %0d actual %0d", $time, exp_v, v);
				mismatches++;
			end
			if (st !== exp_s) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_s, st);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pfx_sym_if sym_bus ();
	pfx_res_if res_bus ();

	postfix_expression_evaluator_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sym    (sym_bus),
		.res    (res_bus)
	);

	rpn_scoreboard board;
	logic [SYM_W-1:0] char_stream [$];
	bit quiet = 1'b0;
	int unsigned results_taken = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [SYM_W-1:0] pick_digit();
		return CHAR_ZERO + SYM_W'($urandom_range(0, 9));
	endfunction

	function automatic logic [SYM_W-1:0] pick_op();
		case ($urandom_range(0, 9))
		0, 1, 2: return CHAR_PLUS;
		3, 4: return CHAR_MINUS;
		5, 6, 7: return CHAR_STAR;
		default: return CHAR_SLASH;
		endcase
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			char_stream.push_back(s[i]);
		end
	endfunction

	// Mostly well-formed expressions with random operands; the rest push 15 to 19 digits
	// against a 16-entry stack, mix operators and digits at random, or carry raw bytes.
	function automatic void add_expression();
		int unsigned kind;
		int unsigned depth;
		kind = $urandom_range(0, 99);
		depth = 0;
		if (kind < 80) begin
			repeat ($urandom_range(1, 14)) begin
				if (depth >= 2 && (depth >= 15 || $urandom_range(0, 1) == 1)) begin
					char_stream.push_back(pick_op());
					depth--;
				end else begin
					char_stream.push_back(pick_digit());
					depth++;
				end
				if ($urandom_range(0, 49) == 0) begin
					char_stream.push_back(SYM_W'($urandom_range(0, 255)));
				end
			end
			while (depth > 1 && $urandom_range(0, 9) != 0) begin
				char_stream.push_back(pick_op());
				depth--;
			end
		end else if (kind < 87) begin
			repeat ($urandom_range(15, 19)) begin
				char_stream.push_back(pick_digit());
			end
			repeat ($urandom_range(0, 3)) begin
				char_stream.push_back(pick_op());
			end
		end else if (kind < 94) begin
			repeat ($urandom_range(1, 6)) begin
				char_stream.push_back($urandom_range(0, 1) ? pick_op() : pick_digit());
			end
		end else begin
			repeat ($urandom_range(1, 4)) begin
				char_stream.push_back(SYM_W'($urandom_range(0, 255)));
			end
		end
		char_stream.push_back(CHAR_NL);
	endfunction

	task automatic send_symbol(input logic [SYM_W-1:0] c);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 16) begin
			sym_bus.valid <= 1'b0;
			@(negedge clk);
		end
		sym_bus.valid <= 1'b1;
		sym_bus.symbol <= c;
		do @(posedge clk); while (!sym_bus.ready);
		board.note_symbol(c);
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		sym_bus.valid <= 1'b0;
		sym_bus.symbol <= '0;

		add_text("\n");
		add_text("3+4+\n");
		add_text("50/\n");
		add_text("1?2/\n");
		add_text("03-7/\n");
		add_text("09-99**9*9*\n");
		while (char_stream.size() < 1630) begin
			add_expression();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < char_stream.size(); i++) begin
			quiet = (i >= 700 && i < 1000);
			// Let every result that is still due be taken before carrying on.
			if (i == 400) begin
				@(negedge clk);
				sym_bus.valid <= 1'b0;
				while (board.outstanding() != 0) @(negedge clk);
			end
			send_symbol(char_stream[i]);
		end
		@(negedge clk);
		sym_bus.valid <= 1'b0;

		while (board.outstanding() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("postfix_expression_evaluator_unit regression: pass");
		end else begin
			$display("postfix_expression_evaluator_unit regression: fail");
		end
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off so that a
	// result sits in the output register while the next newline waits.
	initial begin
		int unsigned hold;
		bit held;
		hold = 0;
		held = 1'b0;
		res_bus.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_taken == 30) begin
				held = 1'b1;
				hold = 300;
			end
			if (hold != 0) begin
				hold--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= quiet || $urandom_range(0, 99) >= 16;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			board.check_result(res_bus.result_value, res_bus.status);
			results_taken <= results_taken + 1;
		end
	end

	initial begin
		#5ms;
		$display("postfix_expression_evaluator_unit regression: fail");
		$finish;
	end

endmodule
